### hdl/ctse_pkg.sv
// ctse_pkg: shared types, codes and field limits for the clock time set editor.
// No dependencies; used by ctse_if.sv and clock_time_set_editor.sv.

package ctse_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_SET  = 2'd1,
    MODE_INC  = 2'd2,
    MODE_DEC  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    F_IDLE    = 3'd0,
    F_YEAR    = 3'd1,
    F_MONTH   = 3'd2,
    F_DAY     = 3'd3,
    F_HOUR    = 3'd4,
    F_MINUTE  = 3'd5,
    F_WEEKDAY = 3'd6
  } field_t;

  localparam logic [6:0] YEAR_RST    = 7'd0;
  localparam logic [3:0] MONTH_RST   = 4'd1;
  localparam logic [4:0] DAY_RST     = 5'd1;
  localparam logic [4:0] HOUR_RST    = 5'd0;
  localparam logic [5:0] MINUTE_RST  = 6'd0;
  localparam logic [2:0] WEEKDAY_RST = 3'd1;

  localparam logic [6:0] LO_ZERO     = 7'd0;
  localparam logic [6:0] LO_ONE      = 7'd1;
  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [6:0] MONTH_MAX   = 7'd12;
  localparam logic [6:0] HOUR_MAX    = 7'd23;
  localparam logic [6:0] MINUTE_MAX  = 7'd59;
  localparam logic [6:0] WEEKDAY_MAX = 7'd7;

  localparam logic [6:0] DAYS_FEB_LEAP = 7'd29;
  localparam logic [6:0] DAYS_FEB      = 7'd28;
  localparam logic [6:0] DAYS_SHORT    = 7'd30;
  localparam logic [6:0] DAYS_LONG     = 7'd31;

  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] load_year;
    logic [3:0] load_month;
    logic [4:0] load_day;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [2:0] load_weekday;
  } evt_t;

  typedef struct packed {
    logic [2:0] edit_field;
    logic [6:0] cur_year;
    logic [3:0] cur_month;
    logic [4:0] cur_day;
    logic [4:0] cur_hour;
    logic [5:0] cur_minute;
    logic [2:0] cur_weekday;
    logic       commit;
  } res_t;

endpackage

### hdl/ctse_if.sv
// ctse_if: valid/ready channel interfaces for button events and results.
// Depends on ctse_pkg for the payload structs.

interface ctse_evt_if;
  logic              valid;
  logic              ready;
  ctse_pkg::evt_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ctse_res_if;
  logic              valid;
  logic              ready;
  ctse_pkg::res_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hdl/clock_time_set_editor.sv
// clock_time_set_editor: three-button date and time editor, top level.
// Depends on ctse_pkg and the channel interfaces in ctse_if.sv.
//
// Usage:
//   evt carries one beat per event: a load of the running calendar time or
//   a SET, INC or DEC button press. res returns exactly one beat per event
//   with the edit position, the held date and time, and a commit flag that
//   is set only on the SET that closes the weekday field (write the time
//   with seconds zeroed).
//   Latency: the result beat is valid the cycle after the event is taken.
//   Throughput: one event per cycle while res stays ready. The field update
//   is a single increment/compare/select on the held registers, done in
//   the cycle the beat is accepted, so the next beat may follow at once.
//   Stall: a single result register sits on res. While it holds a beat that
//   res has not taken, evt.ready is low; when res takes it, a new event is
//   accepted in the same cycle.
//   Reset (rst, synchronous): idle, year 0, month 1, day 1, hour 0,
//   minute 0, weekday 1; no result pending.

module clock_time_set_editor (
  input  logic             clk,
  input  logic             rst,
  ctse_evt_if.sink         evt,
  ctse_res_if.source       res
);

  ctse_pkg::field_t step, step_next;
  logic [6:0] year,    year_next;
  logic [3:0] month,   month_next;
  logic [4:0] day,     day_next;
  logic [4:0] hour,    hour_next;
  logic [5:0] minute,  minute_next;
  logic [2:0] weekday, weekday_next;
  logic       commit_next;
  logic       acc;
  logic [6:0] day_max;
  logic       res_valid;
  ctse_pkg::res_t res_data;

  function automatic logic [6:0] adj(input logic [6:0] v, input logic [6:0] lo,
                                     input logic [6:0] hi, input logic [1:0] m);
    logic [7:0] n;
    n = {1'b0, v} + 8'd1;
    case (m)
      ctse_pkg::MODE_INC: adj = (n > {1'b0, hi}) ? lo : n[6:0];
      ctse_pkg::MODE_DEC: adj = ((v == 7'd0) || ((v - 7'd1) < lo)) ? hi : v - 7'd1;
      ctse_pkg::MODE_SET: adj = (v > hi) ? hi : v;
      default:            adj = v;
    endcase
  endfunction

  assign evt.ready = !res_valid || res.ready;
  assign acc       = evt.valid && evt.ready;

  always_comb begin
    if (month == ctse_pkg::MON_FEB) begin
      day_max = (year[1:0] == 2'b00) ? ctse_pkg::DAYS_FEB_LEAP : ctse_pkg::DAYS_FEB;
    end else if (month == ctse_pkg::MON_APR || month == ctse_pkg::MON_JUN ||
                 month == ctse_pkg::MON_SEP || month == ctse_pkg::MON_NOV) begin
      day_max = ctse_pkg::DAYS_SHORT;
    end else begin
      day_max = ctse_pkg::DAYS_LONG;
    end
  end

  // edit position
  always_comb begin
    step_next   = step;
    commit_next = 1'b0;
    if (acc && evt.payload.mode == ctse_pkg::MODE_SET) begin
      case (step)
        ctse_pkg::F_YEAR:    step_next = ctse_pkg::F_MONTH;
        ctse_pkg::F_MONTH:   step_next = ctse_pkg::F_DAY;
        ctse_pkg::F_DAY:     step_next = ctse_pkg::F_HOUR;
        ctse_pkg::F_HOUR:    step_next = ctse_pkg::F_MINUTE;
        ctse_pkg::F_MINUTE:  step_next = ctse_pkg::F_WEEKDAY;
        ctse_pkg::F_WEEKDAY: begin
          step_next   = ctse_pkg::F_IDLE;
          commit_next = 1'b1;
        end
        default:             step_next = ctse_pkg::F_YEAR;
      endcase
    end else if (acc) begin
      case (step)
        ctse_pkg::F_YEAR, ctse_pkg::F_MONTH, ctse_pkg::F_DAY, ctse_pkg::F_HOUR,
        ctse_pkg::F_MINUTE, ctse_pkg::F_WEEKDAY: step_next = step;
        default:                                 step_next = ctse_pkg::F_IDLE;
      endcase
    end
  end

  // held values
  always_comb begin
    logic [6:0] r;
    r            = 7'd0;
    year_next    = year;
    month_next   = month;
    day_next     = day;
    hour_next    = hour;
    minute_next  = minute;
    weekday_next = weekday;
    if (acc) begin
      case (step)
        ctse_pkg::F_YEAR: begin
          year_next = adj(year, ctse_pkg::LO_ZERO, ctse_pkg::YEAR_MAX, evt.payload.mode);
        end
        ctse_pkg::F_MONTH: begin
          r = adj({3'd0, month}, ctse_pkg::LO_ONE, ctse_pkg::MONTH_MAX, evt.payload.mode);
          month_next = r[3:0];
        end
        ctse_pkg::F_DAY: begin
          r = adj({2'd0, day}, ctse_pkg::LO_ONE, day_max, evt.payload.mode);
          day_next = r[4:0];
        end
        ctse_pkg::F_HOUR: begin
          r = adj({2'd0, hour}, ctse_pkg::LO_ZERO, ctse_pkg::HOUR_MAX, evt.payload.mode);
          hour_next = r[4:0];
        end
        ctse_pkg::F_MINUTE: begin
          r = adj({1'b0, minute}, ctse_pkg::LO_ZERO, ctse_pkg::MINUTE_MAX, evt.payload.mode);
          minute_next = r[5:0];
        end
        ctse_pkg::F_WEEKDAY: begin
          r = adj({4'd0, weekday}, ctse_pkg::LO_ONE, ctse_pkg::WEEKDAY_MAX, evt.payload.mode);
          weekday_next = r[2:0];
        end
        default: begin
          if (evt.payload.mode == ctse_pkg::MODE_LOAD) begin
            year_next    = evt.payload.load_year;
            month_next   = evt.payload.load_month;
            day_next     = evt.payload.load_day;
            hour_next    = evt.payload.load_hour;
            minute_next  = evt.payload.load_minute;
            weekday_next = evt.payload.load_weekday;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= ctse_pkg::F_IDLE;
      year    <= ctse_pkg::YEAR_RST;
      month   <= ctse_pkg::MONTH_RST;
      day     <= ctse_pkg::DAY_RST;
      hour    <= ctse_pkg::HOUR_RST;
      minute  <= ctse_pkg::MINUTE_RST;
      weekday <= ctse_pkg::WEEKDAY_RST;
    end else begin
      step    <= step_next;
      year    <= year_next;
      month   <= month_next;
      day     <= day_next;
      hour    <= hour_next;
      minute  <= minute_next;
      weekday <= weekday_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (acc) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_data.edit_field  <= step_next;
      res_data.cur_year    <= year_next;
      res_data.cur_month   <= month_next;
      res_data.cur_day     <= day_next;
      res_data.cur_hour    <= hour_next;
      res_data.cur_minute  <= minute_next;
      res_data.cur_weekday <= weekday_next;
      res_data.commit      <= commit_next;
    end
  end

  assign res.valid   = res_valid;
  assign res.payload = res_data;

  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.commit |-> res_data.edit_field == ctse_pkg::F_IDLE)
    else $error("commit beat not idle");

  a_set_starts: assert property (@(posedge clk) disable iff (rst)
    acc && step == ctse_pkg::F_IDLE && evt.payload.mode == ctse_pkg::MODE_SET
    |=> step == ctse_pkg::F_YEAR)
    else $error("SET from idle did not start at year");

  a_hold_step: assert property (@(posedge clk) disable iff (rst)
    acc && step != ctse_pkg::F_IDLE && evt.payload.mode != ctse_pkg::MODE_SET
    |=> $stable(step))
    else $error("edit position moved without SET");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.ready |-> !acc)
    else $error("event taken over a pending result");

  a_res_mirror: assert property (@(posedge clk) disable iff (rst)
    acc |=> res_valid && res_data.cur_year == year && res_data.cur_day == day)
    else $error("result beat does not match held time");

endmodule
